// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with clock and active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, checked on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication between two conditions.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/rbb_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbb_pkg
// Constants, types and helpers shared by the 3x3 box blur modules.
// ---------------------------------------------------------------------------
package rbb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int CFG_W   = 12;
  localparam int COORD_W = 11;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 3;
  localparam int PIX_W   = NUM_CH * CH_W;
  localparam int CS_W    = CH_W + 2;   // sum of three bytes
  localparam int SUM_W   = CH_W + 4;   // sum of nine bytes

  // Truncating divide by nine: floor(s * 7282 / 2^16) is exact for s < 2296.
  localparam int DIV9_W     = 13;
  localparam int DIV9_SHIFT = 16;
  localparam logic [DIV9_W-1:0] DIV9_MUL = DIV9_W'(7282);

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [NUM_CH-1:0][SUM_W-1:0] sums_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               filt;    // completes the neighborhood of (row-1, col-1)
    logic               border;  // this pixel is passed through
    logic               up1_en;  // line store A holds row-1 at this column
    logic               up2_en;  // line store B holds row-2 at this column
  } pos_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic               filt;
    logic               last;
  } result_t;

  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [SUM_W+DIV9_W-1:0] prod;
    prod = (SUM_W+DIV9_W)'(s) * (SUM_W+DIV9_W)'(DIV9_MUL);
    return prod[DIV9_SHIFT +: CH_W];
  endfunction

endpackage

// ===== rtl/rbb_pos.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbb_pos
// Raster position counters and per-pixel border and window flags.
// ---------------------------------------------------------------------------
module rbb_pos import rbb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [CFG_W-1:0] width_i,
  input  logic [CFG_W-1:0] height_i,
  output pos_t             pos_o
);

  logic [COORD_W-1:0] col_q, col_d, row_q, row_d;
  logic [COORD_W-1:0] col_c, row_c;
  logic [CFG_W-1:0]   w, h, row_n, col_inc, row_inc;

  always_comb begin
    if (width_i == '0) begin
      w = CFG_W'(1);
    end else if (width_i > CFG_W'(MAX_WIDTH)) begin
      w = CFG_W'(MAX_WIDTH);
    end else begin
      w = width_i;
    end
    if (height_i == '0) begin
      h = CFG_W'(1);
    end else if (height_i > CFG_W'(MAX_HEIGHT)) begin
      h = CFG_W'(MAX_HEIGHT);
    end else begin
      h = height_i;
    end
  end

  // Counters left beyond a shrunken frame size wrap before use.
  always_comb begin
    col_c = col_q;
    row_n = {1'b0, row_q};
    if ({1'b0, col_q} >= w) begin
      col_c = '0;
      row_n = {1'b0, row_q} + CFG_W'(1);
    end
    row_c = (row_n >= h) ? '0 : row_n[COORD_W-1:0];

    col_inc = {1'b0, col_c} + CFG_W'(1);
    row_inc = {1'b0, row_c} + CFG_W'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (adv_i) begin
      if (col_inc >= w) begin
        col_d = '0;
        row_d = (row_inc >= h) ? '0 : row_inc[COORD_W-1:0];
      end else begin
        col_d = col_inc[COORD_W-1:0];
        row_d = row_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    pos_o.col    = col_c;
    pos_o.row    = row_c;
    pos_o.filt   = (row_c >= COORD_W'(2)) && (col_c >= COORD_W'(2));
    pos_o.border = (row_c == '0) || ({1'b0, row_c} == h - CFG_W'(1)) ||
                   (col_c == '0) || ({1'b0, col_c} == w - CFG_W'(1));
    pos_o.up1_en = (row_c != '0);
    pos_o.up2_en = (row_c >= COORD_W'(2));
  end

endmodule

// ===== rtl/rbb_line_buf.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbb_line_buf
// Both line stores in one wide memory, with a write-to-read bypass.
// ---------------------------------------------------------------------------
module rbb_line_buf import rbb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [COORD_W-1:0] rd_addr_i,
  input  logic               wr_en_i,
  input  logic [COORD_W-1:0] wr_addr_i,
  input  logic [2*PIX_W-1:0] wr_data_i,
  output logic [2*PIX_W-1:0] rd_data_o
);

  // Upper half holds the previous row, lower half the row before it.
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q, byp_data_q;
  logic               byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // A one-column frame reads the entry written in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

// ===== rtl/rbb_win.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbb_win
// 3x3 window kept as per-column channel sums; gives the nine-pixel sums.
// ---------------------------------------------------------------------------
module rbb_win import rbb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  pix_t  up2_i,
  input  pix_t  up1_i,
  input  pix_t  pix_i,
  output sums_t sum_o
);

  // Column sums of the two older window columns.
  logic [NUM_CH-1:0][CS_W-1:0] cs_old_q, cs_mid_q, cs_new;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      cs_new[k] = CS_W'(up2_i[k*CH_W +: CH_W]) + CS_W'(up1_i[k*CH_W +: CH_W]) +
                  CS_W'(pix_i[k*CH_W +: CH_W]);
      sum_o[k]  = SUM_W'(cs_old_q[k]) + SUM_W'(cs_mid_q[k]) + SUM_W'(cs_new[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_old_q <= '0;
      cs_mid_q <= '0;
    end else if (adv_i) begin
      cs_old_q <= cs_mid_q;
      cs_mid_q <= cs_new;
    end
  end

endmodule

// ===== rtl/rbb_out.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbb_out
// Divide by nine, build up to two results per pixel and queue them.
// ---------------------------------------------------------------------------
module rbb_out import rbb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  pos_t    pos_i,
  input  pix_t    pix_i,
  input  sums_t   sum_i,
  input  logic    out_stall_i,
  output logic    space_ok_o,
  output logic    out_valid_o,
  output result_t result_o
);

  result_t            fifo_q [FIFO_DEPTH];
  result_t            res_f, res_b;
  logic [PTR_W-1:0]   wp_q, rp_q, wp2;
  logic [CNT_W-1:0]   count_q;
  logic [1:0]         push_cnt;
  logic               pop;

  always_comb begin
    res_f.col   = pos_i.col - COORD_W'(1);
    res_f.row   = pos_i.row - COORD_W'(1);
    res_f.red   = div9(sum_i[2]);
    res_f.green = div9(sum_i[1]);
    res_f.blue  = div9(sum_i[0]);
    res_f.filt  = 1'b1;
    res_f.last  = !pos_i.border;

    res_b.col   = pos_i.col;
    res_b.row   = pos_i.row;
    res_b.red   = pix_i[2*CH_W +: CH_W];
    res_b.green = pix_i[CH_W +: CH_W];
    res_b.blue  = pix_i[0 +: CH_W];
    res_b.filt  = 1'b0;
    res_b.last  = 1'b1;
  end

  // The filtered result goes ahead of the pass-through of the same pixel.
  assign push_cnt = push_i ? ({1'b0, pos_i.filt} + {1'b0, pos_i.border}) : 2'd0;
  assign wp2      = wp_q + PTR_W'(pos_i.filt);
  assign pop      = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push_i && pos_i.filt) begin
      fifo_q[wp_q] <= res_f;
    end
    if (push_i && pos_i.border) begin
      fifo_q[wp2] <= res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_q + PTR_W'(push_cnt);
      rp_q    <= rp_q + PTR_W'(pop);
      count_q <= count_q + CNT_W'(push_cnt) - CNT_W'(pop);
    end
  end

  assign space_ok_o  = (count_q <= CNT_W'(FIFO_DEPTH - 2));
  assign out_valid_o = (count_q != '0);
  assign result_o    = fifo_q[rp_q];

endmodule

// ===== rtl/rgb_box_blur_3x3_top.sv =====
`timescale 1ns / 1ps
// Path: each accepted pixel passes stage 1, stage 2 and the result queue before its first result
// is on the output; a second result follows once the first is taken.
// Throughput: one pixel per cycle while each causes at most one result and the queue has
// room; a pixel that causes two results (last column, last row) adds a second beat, and the
// single output port drains the result queue one beat per cycle while it is not stalled.
// Reset: asynchronous, active low; clears counters, window and queue, and loads the
// frame size registers with 640 x 480. The line stores are not cleared.
// ---------------------------------------------------------------------------
// rgb_box_blur_3x3_top
// Streaming 3x3 mean filter over RGB pixels in raster order.
// ---------------------------------------------------------------------------
module rgb_box_blur_3x3_top import rbb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,

  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,

  // Pixel input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CH_W-1:0]    in_red_i,
  input  logic [CH_W-1:0]    in_green_i,
  input  logic [CH_W-1:0]    in_blue_i,

  // Result output channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COORD_W-1:0] out_col_o,
  output logic [COORD_W-1:0] out_row_o,
  output logic [CH_W-1:0]    out_red_o,
  output logic [CH_W-1:0]    out_green_o,
  output logic [CH_W-1:0]    out_blue_o,
  output logic               was_filtered_o,
  output logic               last_of_run_o
);

  // -------------------------------------------------------------------------
  // Configuration registers. Register index is taken from paddr[2]; the
  // byte lane bits are ignored. Writes take effect at the access phase.
  // -------------------------------------------------------------------------
  logic [CFG_W-1:0] width_q, height_q, cfg_rd;
  logic             cfg_we;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(640);
      height_q <= CFG_W'(480);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:  cfg_rd = width_q;
      REG_IMAGE_HEIGHT: cfg_rd = height_q;
      default:          cfg_rd = '0;
    endcase
  end

  assign prdata = {{(32-CFG_W){1'b0}}, cfg_rd};

  // -------------------------------------------------------------------------
  // Pipeline control. Stage 1 holds the accepted pixel while its line store
  // read completes; stage 2 holds the nine-pixel sums; the result queue
  // after it parts the input from the output. Each stage moves whenever the
  // stage after it can take a beat, so a new pixel is taken every cycle
  // while the queue has room for two results.
  // -------------------------------------------------------------------------
  logic  s1_v_q, s2_v_q;
  logic  s1_ready, s2_ready, s1_fire, s2_fire, in_accept, space_ok;
  pos_t  pos, s1_pos_q, s2_pos_q;
  pix_t  s1_pix_q, s2_pix_q;
  sums_t sum, s2_sum_q;

  assign s2_ready   = !s2_v_q || space_ok;
  assign s2_fire    = s2_v_q && space_ok;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign s1_fire    = s1_v_q && s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= in_accept;
      end
      if (s2_ready) begin
        s2_v_q <= s1_fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pos_q <= pos;
      s1_pix_q <= {in_red_i, in_green_i, in_blue_i};
    end
    if (s1_fire) begin
      s2_pos_q <= s1_pos_q;
      s2_pix_q <= s1_pix_q;
      s2_sum_q <= sum;
    end
  end

  // Position of the pixel being accepted; counters advance on acceptance.
  rbb_pos u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (in_accept),
    .width_i  (width_q),
    .height_i (height_q),
    .pos_o    (pos)
  );

  // -------------------------------------------------------------------------
  // Line stores. The read is issued as the pixel is accepted and used in
  // stage 1; the entry is rewritten with this pixel and the row above as the
  // pixel leaves stage 1. Rows 0 and 1 mask the taps they have not written.
  // -------------------------------------------------------------------------
  logic [2*PIX_W-1:0] ls_rd;
  pix_t               up1, up2;

  assign up1 = s1_pos_q.up1_en ? ls_rd[PIX_W +: PIX_W] : '0;
  assign up2 = s1_pos_q.up2_en ? ls_rd[0 +: PIX_W]     : '0;

  rbb_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (pos.col),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_pos_q.col),
    .wr_data_i ({s1_pix_q, up1}),
    .rd_data_o (ls_rd)
  );

  // Window shift and nine-pixel sums for the column entering in stage 1.
  rbb_win u_win (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s1_fire),
    .up2_i  (up2),
    .up1_i  (up1),
    .pix_i  (s1_pix_q),
    .sum_o  (sum)
  );

  // -------------------------------------------------------------------------
  // Divide by nine and result queue. A pixel that completes a neighborhood
  // and is itself on the border pushes two beats: filtered, then border.
  // -------------------------------------------------------------------------
  result_t result;

  rbb_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_fire),
    .pos_i       (s2_pos_q),
    .pix_i       (s2_pix_q),
    .sum_i       (s2_sum_q),
    .out_stall_i (out_stall_i),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign out_col_o      = result.col;
  assign out_row_o      = result.row;
  assign out_red_o      = result.red;
  assign out_green_o    = result.green;
  assign out_blue_o     = result.blue;
  assign was_filtered_o = result.filt;
  assign last_of_run_o  = result.last;

endmodule

// ===== rtl/rbb_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbb_checker
// Port-level checks on the result stream of the box blur top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rbb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [10:0] out_col_o,
  input logic [10:0] out_row_o,
  input logic [7:0]  out_red_o,
  input logic [7:0]  out_green_o,
  input logic [7:0]  out_blue_o,
  input logic        was_filtered_o,
  input logic        last_of_run_o
);

  // A stalled beat stays on the port unchanged.
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_col_o) &&
    $stable(out_row_o) && $stable(out_red_o) && $stable(out_green_o) &&
    $stable(out_blue_o) && $stable(was_filtered_o) && $stable(last_of_run_o),
    "stalled output beat changed")

  // A border pass-through is always the final result of its pixel.
  `ASSERT_IMPLIES(a_border_last, clk_i, rst_ni,
    out_valid_o && !was_filtered_o, last_of_run_o,
    "border result not marked last")

  // A filtered pixel is never on the first row or column.
  `ASSERT_IMPLIES(a_filt_interior, clk_i, rst_ni,
    out_valid_o && was_filtered_o, out_col_o != 11'd0 && out_row_o != 11'd0,
    "filtered result at a border position")

  // A filtered result that is not last is followed at once by its border pair.
  `ASSERT_PROP(a_pair_follows, clk_i, rst_ni,
    out_valid_o && was_filtered_o && !last_of_run_o && !out_stall_i |=>
    out_valid_o && !was_filtered_o && last_of_run_o,
    "second result of a pixel missing")

endmodule

bind rgb_box_blur_3x3_top rbb_checker u_rbb_checker (.*);
